// ===== design/gsfv_pkg.sv =====
// ----------------------------------------------------------------------------
// gsfv_pkg
// Shared types, constants and the exp factor table of the field-map block.
// ----------------------------------------------------------------------------
package gsfv_pkg;

  localparam int unsigned MaxGauss = 16;
  localparam int unsigned SlotW    = $clog2(MaxGauss);
  localparam int unsigned CntW     = $clog2(MaxGauss + 1);
  localparam int unsigned IndexW   = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned AccW     = 48;
  localparam int unsigned TBits    = 20;

  localparam logic [CfgIdxW-1:0] CfgGradX  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGradY  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGradZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOffset = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCount  = 3'd4;

  localparam logic [30:0] OneQ30 = 31'd1073741824;

  typedef enum logic [3:0] {
    MulNone,
    MulRx,
    MulRy,
    MulRz,
    MulSx,
    MulSy,
    MulSz,
    MulExp,
    MulCon
  } mul_sel_e;

  typedef struct packed {
    logic         capture;
    logic         tbl_wr;
    logic         ent_ld;
    logic         acc_init;
    logic         acc_add_prod;
    logic         acc_add_con;
    logic         d2_ld;
    logic         d2_add;
    logic         div_init;
    logic         div_step;
    logic         ex_init;
    logic         ex_rnd;
    logic         out_ld;
    mul_sel_e     mul_sel;
    logic [4:0]   bit_idx;
    logic [SlotW-1:0] slot_idx;
  } cmd_t;

  typedef struct packed {
    logic            var_zero;
    logic            div_ovf;
    logic [CntW-1:0] n_eff;
  } status_t;

  // exp(-w) in Q1.30 for bit b of t (bits 19..16 weigh 8,4,2,1; bit b<16 weighs 2^-(16-b))
  function automatic logic [30:0] exp_factor(input logic [4:0] b);
    logic [30:0] f;
    unique case (b)
      5'd0:    f = 31'd1073725440;
      5'd1:    f = 31'd1073709056;
      5'd2:    f = 31'd1073676290;
      5'd3:    f = 31'd1073610760;
      5'd4:    f = 31'd1073479712;
      5'd5:    f = 31'd1073217664;
      5'd6:    f = 31'd1072693760;
      5'd7:    f = 31'd1071646719;
      5'd8:    f = 31'd1069555701;
      5'd9:    f = 31'd1065385899;
      5'd10:   f = 31'd1057095000;
      5'd11:   f = 31'd1040706261;
      5'd12:   f = 31'd1008687096;
      5'd13:   f = 31'd947573834;
      5'd14:   f = 31'd836230973;
      5'd15:   f = 31'd651257337;
      5'd16:   f = 31'd395007542;
      5'd17:   f = 31'd145315154;
      5'd18:   f = 31'd19666268;
      5'd19:   f = 31'd360200;
      default: f = OneQ30;
    endcase
    return f;
  endfunction

endpackage

// ===== design/gsfv_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsfv_ctrl
// Sequencer: ramp, then per Gaussian squares, divide, exp and accumulate.
// ----------------------------------------------------------------------------
module gsfv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  gsfv_pkg::status_t   status_i,
  output gsfv_pkg::cmd_t      cmd_o
);

  typedef enum logic [11:0] {
    SIdle = 12'b000000000001,
    SRamp = 12'b000000000010,
    SGChk = 12'b000000000100,
    SGLd  = 12'b000000001000,
    SGVar = 12'b000000010000,
    SSq   = 12'b000000100000,
    SDChk = 12'b000001000000,
    SDiv  = 12'b000010000000,
    SExp  = 12'b000100000000,
    SCMul = 12'b001000000000,
    SCAdd = 12'b010000000000,
    SFin  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [gsfv_pkg::CntW-1:0] gi_q, gi_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gi_d        = gi_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_sel  = gsfv_pkg::MulNone;
    cmd_o.slot_idx = gi_q[gsfv_pkg::SlotW-1:0];
    cmd_o.bit_idx  = cnt_q[4:0];
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          if (in_kind_i) begin
            cmd_o.capture = 1'b1;
            cnt_d   = '0;
            state_d = SRamp;
          end else begin
            cmd_o.tbl_wr = 1'b1;
          end
        end
      end
      SRamp: begin
        cnt_d = cnt_q + 6'd1;
        unique case (cnt_q[1:0])
          2'd0: begin
            cmd_o.acc_init = 1'b1;
            cmd_o.mul_sel  = gsfv_pkg::MulRx;
          end
          2'd1: begin
            cmd_o.acc_add_prod = 1'b1;
            cmd_o.mul_sel      = gsfv_pkg::MulRy;
          end
          2'd2: begin
            cmd_o.acc_add_prod = 1'b1;
            cmd_o.mul_sel      = gsfv_pkg::MulRz;
          end
          default: begin
            cmd_o.acc_add_prod = 1'b1;
            gi_d    = '0;
            state_d = SGChk;
          end
        endcase
      end
      SGChk: begin
        if (gi_q >= status_i.n_eff) begin
          state_d = SFin;
        end else begin
          cmd_o.ent_ld = 1'b1;
          state_d = SGLd;
        end
      end
      SGLd: state_d = SGVar;
      SGVar: begin
        cmd_o.ex_init = 1'b1;
        if (status_i.var_zero) begin
          gi_d    = gi_q + 1'b1;
          state_d = SGChk;
        end else begin
          cnt_d   = '0;
          state_d = SSq;
        end
      end
      SSq: begin
        cnt_d = cnt_q + 6'd1;
        unique case (cnt_q[1:0])
          2'd0: cmd_o.mul_sel = gsfv_pkg::MulSx;
          2'd1: begin
            cmd_o.d2_ld   = 1'b1;
            cmd_o.mul_sel = gsfv_pkg::MulSy;
          end
          2'd2: begin
            cmd_o.d2_add  = 1'b1;
            cmd_o.mul_sel = gsfv_pkg::MulSz;
          end
          default: begin
            cmd_o.d2_add = 1'b1;
            state_d = SDChk;
          end
        endcase
      end
      SDChk: begin
        cmd_o.div_init = 1'b1;
        if (status_i.div_ovf) begin
          // exp underflows to zero: nothing to add
          gi_d    = gi_q + 1'b1;
          state_d = SGChk;
        end else begin
          cnt_d   = 6'(gsfv_pkg::TBits - 1);
          state_d = SDiv;
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          cnt_d   = 6'(2 * gsfv_pkg::TBits - 1);
          state_d = SExp;
        end
      end
      SExp: begin
        cmd_o.bit_idx = cnt_q[5:1];
        cnt_d = cnt_q - 6'd1;
        if (cnt_q[0]) begin
          cmd_o.mul_sel = gsfv_pkg::MulExp;
        end else begin
          cmd_o.ex_rnd = 1'b1;
          if (cnt_q == '0) state_d = SCMul;
        end
      end
      SCMul: begin
        cmd_o.mul_sel = gsfv_pkg::MulCon;
        state_d = SCAdd;
      end
      SCAdd: begin
        cmd_o.acc_add_con = 1'b1;
        gi_d    = gi_q + 1'b1;
        state_d = SGChk;
      end
      SFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      gi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gi_q        <= gi_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/gsfv_dp.sv =====
// ----------------------------------------------------------------------------
// gsfv_dp
// Datapath: config registers, Gaussian tables, shared multiplier, divider,
// exp accumulator and the output register.
// ----------------------------------------------------------------------------
module gsfv_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gsfv_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic [gsfv_pkg::IndexW-1:0]        index_x_i,
  input  logic [gsfv_pkg::IndexW-1:0]        index_y_i,
  input  logic [gsfv_pkg::IndexW-1:0]        index_z_i,
  input  logic signed [31:0]                 pos_x_i,
  input  logic signed [31:0]                 pos_y_i,
  input  logic signed [31:0]                 pos_z_i,
  input  logic [gsfv_pkg::SlotW-1:0]         slot_i,
  input  logic signed [31:0]                 height_i,
  input  logic [31:0]                        variance_i,
  input  gsfv_pkg::cmd_t                     cmd_i,
  output gsfv_pkg::status_t                  status_o,
  output logic signed [31:0]                 field_value_o,
  output logic                               saturated_o
);

  localparam int unsigned AccW = gsfv_pkg::AccW;

  logic signed [31:0] gx_q, gy_q, gz_q, off_q;
  logic [gsfv_pkg::CntW-1:0] cnt_cfg_q;

  logic [31:0] cx_mem [gsfv_pkg::MaxGauss];
  logic [31:0] cy_mem [gsfv_pkg::MaxGauss];
  logic [31:0] cz_mem [gsfv_pkg::MaxGauss];
  logic [31:0] h_mem  [gsfv_pkg::MaxGauss];
  logic [31:0] v_mem  [gsfv_pkg::MaxGauss];

  logic [gsfv_pkg::IndexW-1:0] ix_q, iy_q, iz_q;
  logic [31:0] px_q, py_q, pz_q;
  logic [31:0] cx_q, cy_q, cz_q, hgt_q, var_q;

  logic signed [AccW-1:0] acc_q;
  logic signed [65:0] p_q;
  logic [63:0] d2_q;
  logic [32:0] rem_q;
  logic [gsfv_pkg::TBits-1:0] t_q;
  logic [30:0] ex_q;
  logic signed [31:0] field_q;
  logic sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q      <= '0;
      gy_q      <= '0;
      gz_q      <= '0;
      off_q     <= '0;
      cnt_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gsfv_pkg::CfgGradX:  gx_q      <= cfg_data_i;
        gsfv_pkg::CfgGradY:  gy_q      <= cfg_data_i;
        gsfv_pkg::CfgGradZ:  gz_q      <= cfg_data_i;
        gsfv_pkg::CfgOffset: off_q     <= cfg_data_i;
        gsfv_pkg::CfgCount:  cnt_cfg_q <= cfg_data_i[gsfv_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign status_o.n_eff = (cnt_cfg_q > gsfv_pkg::CntW'(gsfv_pkg::MaxGauss))
                        ? gsfv_pkg::CntW'(gsfv_pkg::MaxGauss) : cnt_cfg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) begin
      cx_mem[slot_i] <= pos_x_i;
      cy_mem[slot_i] <= pos_y_i;
      cz_mem[slot_i] <= pos_z_i;
      h_mem[slot_i]  <= height_i;
      v_mem[slot_i]  <= variance_i;
    end
    if (cmd_i.ent_ld) begin
      cx_q  <= cx_mem[cmd_i.slot_idx];
      cy_q  <= cy_mem[cmd_i.slot_idx];
      cz_q  <= cz_mem[cmd_i.slot_idx];
      hgt_q <= h_mem[cmd_i.slot_idx];
      var_q <= v_mem[cmd_i.slot_idx];
    end
    if (cmd_i.capture) begin
      ix_q <= index_x_i;
      iy_q <= index_y_i;
      iz_q <= index_z_i;
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
    end
  end

  assign status_o.var_zero = (var_q == '0);

  // absolute coordinate differences, at most 2^32-1
  logic signed [32:0] dx, dy, dz;
  logic [32:0] ax, ay, az;
  assign dx = {px_q[31], px_q} - {cx_q[31], cx_q};
  assign dy = {py_q[31], py_q} - {cy_q[31], cy_q};
  assign dz = {pz_q[31], pz_q} - {cz_q[31], cz_q};
  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);
  assign az = dz[32] ? 33'(-dz) : 33'(dz);

  logic [16:0] e_q16;
  logic [31:0] e_sum;
  assign e_sum = {1'b0, ex_q} + 32'd8192;
  assign e_q16 = e_sum[30:14];

  logic [30:0] factor;
  assign factor = t_q[cmd_i.bit_idx] ? gsfv_pkg::exp_factor(cmd_i.bit_idx)
                                     : gsfv_pkg::OneQ30;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  always_comb begin
    unique case (cmd_i.mul_sel)
      gsfv_pkg::MulRx: begin ma = {23'b0, ix_q}; mb = {gx_q[31], gx_q}; end
      gsfv_pkg::MulRy: begin ma = {23'b0, iy_q}; mb = {gy_q[31], gy_q}; end
      gsfv_pkg::MulRz: begin ma = {23'b0, iz_q}; mb = {gz_q[31], gz_q}; end
      gsfv_pkg::MulSx: begin ma = ax; mb = ax; end
      gsfv_pkg::MulSy: begin ma = ay; mb = ay; end
      gsfv_pkg::MulSz: begin ma = az; mb = az; end
      gsfv_pkg::MulExp: begin ma = {2'b0, ex_q}; mb = {2'b0, factor}; end
      gsfv_pkg::MulCon: begin ma = {hgt_q[31], hgt_q}; mb = {16'b0, e_q16}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = ma * mb;

  // saturating d2 accumulate
  logic [64:0] d2_sum;
  assign d2_sum = {1'b0, d2_q} + {1'b0, p_q[63:0]};

  // divide by 2*variance, quotient limited to 20 bits
  logic [32:0] dvs;
  logic [33:0] rem_sh;
  logic rem_ge;
  assign dvs    = {var_q, 1'b0};
  assign status_o.div_ovf = (d2_q[63:gsfv_pkg::TBits] >= {11'b0, dvs});
  assign rem_sh = {rem_q, d2_q[cmd_i.bit_idx]};
  assign rem_ge = (rem_sh >= {1'b0, dvs});

  logic [61:0] ex_rnd;
  assign ex_rnd = p_q[61:0] + 62'd536870912;

  logic [48:0] con_sum;
  assign con_sum = p_q[48:0] + 49'd32768;

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    if (cmd_i.acc_init) begin
      acc_q <= AccW'(off_q);
    end else if (cmd_i.acc_add_prod) begin
      acc_q <= acc_q + p_q[AccW-1:0];
    end else if (cmd_i.acc_add_con) begin
      acc_q <= acc_q + {{(AccW-33){con_sum[48]}}, con_sum[48:16]};
    end
    if (cmd_i.d2_ld) begin
      d2_q <= p_q[63:0];
    end else if (cmd_i.d2_add) begin
      d2_q <= d2_sum[64] ? '1 : d2_sum[63:0];
    end
    if (cmd_i.div_init) begin
      rem_q <= d2_q[gsfv_pkg::TBits+32:gsfv_pkg::TBits];
      t_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? 33'(rem_sh - {1'b0, dvs}) : rem_sh[32:0];
      t_q   <= {t_q[gsfv_pkg::TBits-2:0], rem_ge};
    end
    if (cmd_i.ex_init) begin
      ex_q <= gsfv_pkg::OneQ30;
    end else if (cmd_i.ex_rnd) begin
      ex_q <= ex_rnd[60:30];
    end
    if (cmd_i.out_ld) begin
      if (acc_q > AccW'(64'sh7fffffff)) begin
        field_q <= 32'sh7fffffff;
        sat_q   <= 1'b1;
      end else if (acc_q < AccW'(-64'sh80000000)) begin
        field_q <= 32'sh80000000;
        sat_q   <= 1'b1;
      end else begin
        field_q <= acc_q[31:0];
        sat_q   <= 1'b0;
      end
    end
  end

  assign field_value_o = field_q;
  assign saturated_o   = sat_q;

endmodule

// ===== design/gaussian_sum_fieldmap_voxel.sv =====
// ----------------------------------------------------------------------------
// gaussian_sum_fieldmap_voxel
// Field-map value per voxel: linear ramp plus a sum of Gaussian bumps.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): kind 0 loads a Gaussian slot and
// gives no result; kind 1 evaluates a voxel and gives one result item on the
// output channel (out_valid_o/out_ready_i).
// A load item is written in the idle state. An evaluate item's work grows
// with n, the Gaussians in use (less when a slot has zero variance or its exp
// term underflows). Per Gaussian the shared multiplier does three squares and
// twenty exp products, and a one-bit-per-cycle divider gives 20 quotient bits.
// One item is worked on at a time; in_ready_o is high only while idle.
// A finished result sits in an output register; the next item is taken while
// it waits, and a second result holds the sequencer until the first is taken.
// Configuration (cfg_valid_i/cfg_ready_o) is always ready; write it only
// while the block is idle.
// Reset clears the configuration registers and the control; Gaussian slots hold nothing
// meaningful until loaded.
// ----------------------------------------------------------------------------
module gaussian_sum_fieldmap_voxel (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gsfv_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic [gsfv_pkg::IndexW-1:0]        index_x_i,
  input  logic [gsfv_pkg::IndexW-1:0]        index_y_i,
  input  logic [gsfv_pkg::IndexW-1:0]        index_z_i,
  input  logic signed [31:0]                 pos_x_i,
  input  logic signed [31:0]                 pos_y_i,
  input  logic signed [31:0]                 pos_z_i,
  input  logic [gsfv_pkg::SlotW-1:0]         slot_i,
  input  logic signed [31:0]                 height_i,
  input  logic [31:0]                        variance_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [31:0]                 field_value_o,
  output logic                               saturated_o
);

  gsfv_pkg::cmd_t    cmd;
  gsfv_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  gsfv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (kind_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gsfv_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .index_x_i     (index_x_i),
    .index_y_i     (index_y_i),
    .index_z_i     (index_z_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .slot_i        (slot_i),
    .height_i      (height_i),
    .variance_i    (variance_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .field_value_o (field_value_o),
    .saturated_o   (saturated_o)
  );

`ifndef ASSERT_OFF
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (field_value_o == 32'sh7fffffff || field_value_o == 32'sh80000000))
    else $error("saturated result not at a range limit");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !kind_i && !out_valid_o) |=> !out_valid_o)
    else $error("load item produced a result");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && kind_i) |=> !in_ready_o)
    else $error("input taken during evaluation");
`endif

endmodule

// ===== sim/gaussian_sum_fieldmap_voxel_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_sum_fieldmap_voxel_chk
// Watches the config, input and output channels of the field-map block, keeps
// its own copy of the registers and Gaussian slots, predicts each voxel value
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module gaussian_sum_fieldmap_voxel_chk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [gsfv_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              kind_i,
  input  logic [gsfv_pkg::IndexW-1:0]       index_x_i,
  input  logic [gsfv_pkg::IndexW-1:0]       index_y_i,
  input  logic [gsfv_pkg::IndexW-1:0]       index_z_i,
  input  logic signed [31:0]                pos_x_i,
  input  logic signed [31:0]                pos_y_i,
  input  logic signed [31:0]                pos_z_i,
  input  logic [gsfv_pkg::SlotW-1:0]        slot_i,
  input  logic signed [31:0]                height_i,
  input  logic [31:0]                       variance_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [31:0]                field_value_i,
  input  logic                              saturated_i,
  output int                                errors_o,
  output int                                pending_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } voxel_res_t;

  voxel_res_t voxel_q[$];

  logic signed [31:0] gx, gy, gz, goff;
  logic [4:0]         gcnt;
  logic signed [31:0] cx_m[gsfv_pkg::MaxGauss], cy_m[gsfv_pkg::MaxGauss];
  logic signed [31:0] cz_m[gsfv_pkg::MaxGauss], ht_m[gsfv_pkg::MaxGauss];
  logic [31:0]        var_m[gsfv_pkg::MaxGauss];

  // exp(-w) in Q1.30 per bit of t
  localparam logic [30:0] ExpTab[20] = '{
    31'd1073725440, 31'd1073709056, 31'd1073676290, 31'd1073610760,
    31'd1073479712, 31'd1073217664, 31'd1072693760, 31'd1071646719,
    31'd1069555701, 31'd1065385899, 31'd1057095000, 31'd1040706261,
    31'd1008687096, 31'd947573834,  31'd836230973,  31'd651257337,
    31'd395007542,  31'd145315154,  31'd19666268,   31'd360200};

  function automatic logic [63:0] abs_sq(input logic signed [63:0] d);
    logic [63:0] u;
    u = (d < 0) ? -d : d;
    return u * u;
  endfunction

  function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] t);
    logic [63:0] e;
    if (t >= (64'd16 << 16)) return 64'd0;
    e = 64'd1073741824;
    for (int b = 19; b >= 0; b--)
      if (t[b]) e = (e * ExpTab[b] + 64'd536870912) >> 30;
    return (e + 64'd8192) >> 14;
  endfunction

  function automatic voxel_res_t field_at(input logic [gsfv_pkg::IndexW-1:0] ix, iy, iz,
                                          input logic signed [31:0] px, py, pz);
    voxel_res_t r;
    logic signed [63:0] acc, prod;
    logic [63:0] d2, t, e;
    int n;
    acc = $signed({54'd0, ix}) * 64'(gx) + $signed({54'd0, iy}) * 64'(gy)
        + $signed({54'd0, iz}) * 64'(gz) + 64'(goff);
    n = (gcnt > gsfv_pkg::MaxGauss) ? gsfv_pkg::MaxGauss : gcnt;
    for (int i = 0; i < n; i++) begin
      if (var_m[i] != 0) begin
        d2 = abs_sq(64'(px) - 64'(cx_m[i]));
        d2 = sum_sat(d2, abs_sq(64'(py) - 64'(cy_m[i])));
        d2 = sum_sat(d2, abs_sq(64'(pz) - 64'(cz_m[i])));
        t = d2 / (64'd2 * var_m[i]);
        e = exp_neg(t);
        prod = 64'(ht_m[i]) * $signed(e) + 64'sd32768;
        acc += prod >>> 16;  // arithmetic shift is a floor
      end
    end
    r.sat = 1'b1;
    if (acc > 64'sd2147483647) r.value = 32'h7FFF_FFFF;
    else if (acc < -64'sd2147483648) r.value = 32'h8000_0000;
    else begin
      r.value = acc[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch %s got %h want %h", $time, what, got, want);
    errors_o++;
  endtask

  initial errors_o = 0;
  assign pending_o = voxel_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx <= '0; gy <= '0; gz <= '0; goff <= '0; gcnt <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          gsfv_pkg::CfgGradX:  gx   <= cfg_data_i;
          gsfv_pkg::CfgGradY:  gy   <= cfg_data_i;
          gsfv_pkg::CfgGradZ:  gz   <= cfg_data_i;
          gsfv_pkg::CfgOffset: goff <= cfg_data_i;
          gsfv_pkg::CfgCount:  gcnt <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (!kind_i) begin
          cx_m[slot_i] = pos_x_i; cy_m[slot_i] = pos_y_i; cz_m[slot_i] = pos_z_i;
          ht_m[slot_i] = height_i; var_m[slot_i] = variance_i;
        end else begin
          voxel_q.push_back(field_at(index_x_i, index_y_i, index_z_i,
                                     pos_x_i, pos_y_i, pos_z_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (voxel_q.size() == 0) begin
          report("unexpected item", field_value_i, 0);
        end else begin
          voxel_res_t w;
          w = voxel_q.pop_front();
          if (field_value_i !== w.value) report("field_value", field_value_i, w.value);
          if (saturated_i !== w.sat) report("saturated", saturated_i, w.sat);
        end
      end
    end
  end

endmodule

// ===== sim/gaussian_sum_fieldmap_voxel_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_sum_fieldmap_voxel_tb
// Loads Gaussian slots and evaluates voxels under several register settings,
// with random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gaussian_sum_fieldmap_voxel_tb;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [gsfv_pkg::CfgIdxW-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, kind;
  logic [gsfv_pkg::IndexW-1:0] ix, iy, iz;
  logic signed [31:0] px, py, pz, height;
  logic [gsfv_pkg::SlotW-1:0] slot;
  logic [31:0] variance;
  logic out_valid, out_ready;
  logic signed [31:0] field_value;
  logic saturated;
  int errors, pending;
  int hold_cycles;
  bit loaded[gsfv_pkg::MaxGauss];
  int n_loaded;

  gaussian_sum_fieldmap_voxel i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .index_x_i(ix), .index_y_i(iy), .index_z_i(iz),
    .pos_x_i(px), .pos_y_i(py), .pos_z_i(pz), .slot_i(slot),
    .height_i(height), .variance_i(variance),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .field_value_o(field_value), .saturated_o(saturated)
  );

  gaussian_sum_fieldmap_voxel_chk i_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .index_x_i(ix), .index_y_i(iy), .index_z_i(iz),
    .pos_x_i(px), .pos_y_i(py), .pos_z_i(pz), .slot_i(slot),
    .height_i(height), .variance_i(variance),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .field_value_i(field_value), .saturated_i(saturated),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 3_000_000);
    $display("gaussian_sum_fieldmap_voxel verification failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    int unsigned rw;
    out_ready = 1'b0;
    hold_cycles = 0;
    @(posedge clk iff rst_n);
    forever begin
      rw = $urandom_range(0, 9);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (rw > 0) begin
        out_ready <= 1'b0;
        repeat (rw) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  function automatic logic [31:0] rnd_wide();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // valid stays up after acceptance until the next item or an idle point
  task automatic send_item(input logic k, input logic [gsfv_pkg::IndexW-1:0] x, y, z,
                           input logic [31:0] a, b, c,
                           input logic [gsfv_pkg::SlotW-1:0] s,
                           input logic [31:0] h, v, input bit gap);
    int unsigned w;
    w = gap ? $urandom_range(0, 9) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    kind <= k; ix <= x; iy <= y; iz <= z; px <= a; py <= b; pz <= c;
    slot <= s; height <= h; variance <= v; in_valid <= 1'b1;
    @(posedge clk iff in_ready);
    if (!k && !loaded[s]) begin
      loaded[s] = 1'b1;
      n_loaded++;
    end
  endtask

  task automatic load_rand(input logic [gsfv_pkg::SlotW-1:0] s);
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 32'hFFFF_FFFF;
      default: v = $urandom_range(1, 32'h0100_0000);
    endcase
    send_item(0, gsfv_pkg::IndexW'($urandom), gsfv_pkg::IndexW'($urandom),
              gsfv_pkg::IndexW'($urandom), rnd_wide(), rnd_wide(), rnd_wide(),
              s, rnd_wide(), v, 1);
  endtask

  task automatic voxel_rand();
    send_item(1, gsfv_pkg::IndexW'($urandom), gsfv_pkg::IndexW'($urandom),
              gsfv_pkg::IndexW'($urandom), rnd_wide(), rnd_wide(), rnd_wide(),
              gsfv_pkg::SlotW'($urandom), $urandom, $urandom, 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (1300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gsfv_pkg::CfgIdxW-1:0] idx, input logic [31:0] d);
    cfg_index <= idx; cfg_data <= d; cfg_valid <= 1'b1;
    @(posedge clk iff cfg_ready);
  endtask

  task automatic set_regs(input logic [31:0] a, b, c, o, input logic [4:0] n);
    in_valid <= 1'b0;
    write_reg(gsfv_pkg::CfgGradX, a);
    write_reg(gsfv_pkg::CfgGradY, b);
    write_reg(gsfv_pkg::CfgGradZ, c);
    write_reg(gsfv_pkg::CfgOffset, o);
    write_reg(gsfv_pkg::CfgCount, n);
    cfg_valid <= 1'b0;
  endtask

  // count limited to slots already loaded (slots are loaded in order), or 16 to 31 once all are loaded
  task automatic random_phase(input int items);
    logic [4:0] n;
    n = 5'($urandom_range(0, n_loaded));
    if (n_loaded == gsfv_pkg::MaxGauss && $urandom_range(0, 3) == 0)
      n = 5'($urandom_range(16, 31));
    set_regs(rnd_wide(), rnd_wide(), rnd_wide(), rnd_wide(), n);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 3) == 0) load_rand(gsfv_pkg::SlotW'($urandom));
      else voxel_rand();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; kind = 1'b0; ix = '0; iy = '0; iz = '0;
    px = '0; py = '0; pz = '0; slot = '0; height = '0; variance = '0;
    n_loaded = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pure ramp at extremes, count zero
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_item(1, '1, '1, '1, 0, 0, 0, 0, 0, 0, 0);
    send_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();
    set_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_item(1, '1, '1, '1, 0, 0, 0, 0, 0, 0, 0);
    send_item(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // load all slots: on-center bump, zero variance, huge height, max variance
    send_item(0, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
    send_item(0, 0, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, 0, 0);
    send_item(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 2, 32'h8000_0000,
              32'hFFFF_FFFF, 0);
    send_item(0, 0, 0, 0, 32'h0002_0000, 0, 0, 3, 32'h7FFF_FFFF, 1, 0);
    for (int s = 4; s < gsfv_pkg::MaxGauss; s++) load_rand(gsfv_pkg::SlotW'(s));
    set_regs(0, 0, 0, 0, 4);
    send_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send_item(1, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
    send_item(1, 0, 0, 0, 32'h0001_8000, 0, 0, 0, 0, 0, 0);
    drain();
    set_regs(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 31);
    send_item(1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1, 3, 5, 7, 32'h0002_0000, 0, 0, 0, 0, 0, 0);
    drain();

    // receiver stalls long while the sender keeps offering
    hold_cycles = 3000;
    for (int i = 0; i < 8; i++) voxel_rand();
    drain();

    for (int p = 0; p < 12; p++) random_phase(60);
    if (errors == 0) $display("gaussian_sum_fieldmap_voxel verification clean");
    else $display("gaussian_sum_fieldmap_voxel verification failed");
    $finish;
  end

endmodule
